### rtl/edist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edist_pkg;

	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF    = 48;

	localparam int VALUE_W = 16;
	localparam int SQSUM_W = 48;
	localparam int DIST_W  = 24;

	typedef struct packed {
		logic signed [VALUE_W-1:0] a_value;
		logic signed [VALUE_W-1:0] b_value;
		logic                      last_element;
	} item_t;

	typedef struct packed {
		logic [SQSUM_W-1:0] square_sum;
		logic [DIST_W-1:0]  distance;
		logic               saturated;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // load the squaring stage
		logic advance;    // fold the squaring stage into the accumulator
		logic load_root;  // hand the final sum to the root unit
		logic step_root;  // one root bit
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_s1;
	} dp_status_t;

endpackage
`default_nettype wire

### rtl/edist_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module edist_ctrl #(
	parameter int ACC_WIDTH = edist_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	output logic                        result_valid,
	input  wire logic                   result_ready,
	input  wire edist_pkg::dp_status_t  status,
	output edist_pkg::dp_cmd_t          cmd
);
	import edist_pkg::*;

	localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
	localparam int CNT_W  = $clog2(ROOT_W);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROOT = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             valid_s1;
	logic             advance;
	logic             take;

	// a non-final element always drains; a final one waits for a free root unit
	assign advance = valid_s1 && (!status.last_s1 || state_q == ST_IDLE);
	assign item_ready = !valid_s1 || advance;
	assign take = item_valid && item_ready;
	assign result_valid = (state_q == ST_HOLD);

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.advance   = advance;
		cmd.load_root = advance && status.last_s1;
		cmd.step_root = (state_q == ST_ROOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (advance && status.last_s1) begin
						state_q <= ST_ROOT;
						cnt_q   <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(ROOT_W - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/edist_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module edist_dp #(
	parameter int SAMPLE_WIDTH = edist_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_WIDTH    = edist_pkg::ACC_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire edist_pkg::item_t       item,
	input  wire edist_pkg::dp_cmd_t     cmd,
	output edist_pkg::dp_status_t       status,
	output edist_pkg::result_t          result
);
	import edist_pkg::*;

	localparam int SW     = SAMPLE_WIDTH;
	localparam int SQ_W   = 2 * SW + 2;
	localparam int SUM_W  = ((ACC_WIDTH > SQ_W) ? ACC_WIDTH : SQ_W) + 1;
	localparam int ROOT_W = (ACC_WIDTH + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 1;
	localparam int TRY_W  = ROOT_W + 3;

	// squaring stage
	logic [SW-1:0]          a_raw;
	logic [SW-1:0]          b_raw;
	logic signed [SW:0]     diff;
	logic [SW:0]            mag;
	logic [SQ_W-1:0]        sq_s1;
	logic                   last_s1;

	// accumulate stage
	logic [ACC_WIDTH-1:0]   acc_q;
	logic                   ovf_q;
	logic [SUM_W-1:0]       sum;
	logic                   over;
	logic [ACC_WIDTH-1:0]   acc_new;
	logic                   ovf_new;

	// root unit
	logic [RAD_W-1:0]       rad_q;
	logic [REM_W-1:0]       rem_q;
	logic [ROOT_W-1:0]      root_q;
	logic [TRY_W-1:0]       shifted;
	logic [TRY_W-1:0]       trial;
	logic                   fits;
	logic [ACC_WIDTH-1:0]   sqsum_q;
	logic                   sat_q;

	assign a_raw = SW'($unsigned(item.a_value));
	assign b_raw = SW'($unsigned(item.b_value));
	assign diff  = $signed({a_raw[SW-1], a_raw}) - $signed({b_raw[SW-1], b_raw});
	assign mag   = diff[SW] ? $unsigned(-diff) : $unsigned(diff);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sq_s1   <= SQ_W'(mag) * SQ_W'(mag);
			last_s1 <= item.last_element;
		end
	end

	assign status.last_s1 = last_s1;

	assign sum     = SUM_W'(acc_q) + SUM_W'(sq_s1);
	assign over    = sum > SUM_W'({ACC_WIDTH{1'b1}});
	assign acc_new = over ? {ACC_WIDTH{1'b1}} : ACC_WIDTH'(sum);
	assign ovf_new = ovf_q | over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (cmd.advance) begin
			acc_q <= last_s1 ? '0 : acc_new;
			ovf_q <= last_s1 ? 1'b0 : ovf_new;
		end
	end

	// one root bit per step, restoring
	assign shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = TRY_W'({root_q, 2'b01});
	assign fits    = shifted >= trial;

	always_ff @(posedge clk) begin
		if (cmd.load_root) begin
			rad_q   <= RAD_W'(acc_new);
			rem_q   <= '0;
			root_q  <= '0;
			sqsum_q <= acc_new;
			sat_q   <= ovf_new;
		end else if (cmd.step_root) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? REM_W'(shifted - trial) : REM_W'(shifted);
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	always_comb begin
		result            = '0;
		result.square_sum = SQSUM_W'(sqsum_q);
		result.distance   = DIST_W'(root_q);
		result.saturated  = sat_q;
	end

endmodule
`default_nettype wire

### rtl/euclidean_distance_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                  Payload
// item      in   item_valid / item_ready    edist_pkg::item_t   (a_value, b_value, last_element)
// result    out  result_valid / result_ready edist_pkg::result_t (square_sum, distance, saturated)
//
// One element pair is taken per cycle while item_ready is high; the multiply and the
// saturating add are one stage each. A pair marked last moves from the squaring
// stage into the bit-serial square root unit (ROOT_W = (ACC_WIDTH + 1) / 2 root
// bits), which yields one root bit per cycle and then raises result_valid.
// The next vector keeps streaming while the root runs; its own last pair holds in
// the squaring stage until the root unit is idle and the pending result is taken.
// arst_n clears the accumulator, saturation flag and all control state.
module euclidean_distance_engine #(
	parameter int SAMPLE_WIDTH = edist_pkg::SAMPLE_WIDTH_DEF,
	parameter int ACC_WIDTH    = edist_pkg::ACC_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire edist_pkg::item_t   item,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output edist_pkg::result_t      result
);
	import edist_pkg::*;

	// command and status between the sequencer and the datapath
	dp_cmd_t    cmd;
	dp_status_t status;

	// Controller: owns the squaring-stage valid, the accept/advance decision and
	// the root sequencer (idle, stepping, holding the result for the consumer).
	edist_ctrl #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Datapath: difference and square, saturating accumulator, and the root
	// unit whose registers double as the output register.
	edist_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACC_WIDTH    (ACC_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
`default_nettype wire

### rtl/edist_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module edist_checker #(
	parameter int ACC_WIDTH = edist_pkg::ACC_WIDTH_DEF
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_valid,
	input wire logic               result_ready,
	input wire edist_pkg::result_t result
);
	import edist_pkg::*;

	localparam int  MAX_W = (ACC_WIDTH < SQSUM_W) ? ACC_WIDTH : SQSUM_W;
	localparam logic [SQSUM_W-1:0] SUM_MAX = SQSUM_W'({MAX_W{1'b1}});
	localparam bit  EXACT = (ACC_WIDTH <= SQSUM_W);

	logic [2*DIST_W+1:0] dsq;
	logic [2*DIST_W+1:0] dsq_next;

	assign dsq      = (2*DIST_W+2)'(result.distance) * (2*DIST_W+2)'(result.distance);
	assign dsq_next = dsq + (2*DIST_W+2)'({result.distance, 1'b1});

	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a clamped sum sits at the maximum
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.saturated |-> result.square_sum == SUM_MAX)
		else $error("saturated result below maximum");

	// distance is the floor root of the sum, checked when the accumulator fits the sum field
	a_root_lo: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && EXACT |-> dsq <= (2*DIST_W+2)'(result.square_sum))
		else $error("distance too large");

	a_root_hi: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && EXACT |-> dsq_next > (2*DIST_W+2)'(result.square_sum))
		else $error("distance too small");

	// a result leaves only through a transaction
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(result_ready))
		else $error("result withdrawn without a transaction");

endmodule

bind euclidean_distance_engine edist_checker #(
	.ACC_WIDTH (ACC_WIDTH)
) u_edist_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import edist_pkg::*;

	// Largest value the running sum may hold; anything above clamps here.
	localparam logic [SQSUM_W-1:0] SUM_CEILING = '1;
	// Receiver hold-off used to back the block up into its input.
	localparam int LONG_HOLD = 300;
	// Drain margin after the last expected transaction, above the root latency.
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1850;

	typedef enum int {SINK_OPEN, SINK_MOSTLY, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

	// Running model of the accumulator plus the queue of distances still owed by the block.
	class distance_scoreboard;
		logic [SQSUM_W-1:0] running_sum;
		bit                 clamp_seen;
		result_t            pending[$];
		int                 mismatches;

		function new();
			running_sum = '0;
			clamp_seen = 1'b0;
			mismatches = 0;
		endfunction

		function logic [DIST_W-1:0] floor_root(logic [SQSUM_W-1:0] x);
			logic [SQSUM_W-1:0] trial;
			logic [DIST_W-1:0]  root;
			root = '0;
			for (int i = DIST_W - 1; i >= 0; i--) begin
				trial = SQSUM_W'(root | (DIST_W'(1) << i));
				if (trial * trial <= x)
					root = trial[DIST_W-1:0];
			end
			return root;
		endfunction

		// Fold one accepted pair into the sum; queue a result on the last pair.
		function void note_pair(item_t it);
			logic [VALUE_W:0]   diff;
			logic [VALUE_W:0]   mag;
			logic [SQSUM_W-1:0] sq;
			result_t            owed;
			diff = {it.a_value[VALUE_W-1], it.a_value} - {it.b_value[VALUE_W-1], it.b_value};
			mag = diff[VALUE_W] ? -diff : diff;
			sq = SQSUM_W'(mag) * SQSUM_W'(mag);
			if (sq > SUM_CEILING - running_sum) begin
				running_sum = SUM_CEILING;
				clamp_seen = 1'b1;
			end else begin
				running_sum = running_sum + sq;
			end
			if (it.last_element) begin
				owed.square_sum = running_sum;
				owed.distance = floor_root(running_sum);
				owed.saturated = clamp_seen;
				pending.push_back(owed);
				running_sum = '0;
				clamp_seen = 1'b0;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result sum=%0d dist=%0d sat=%0b",
						$time, got.square_sum, got.distance, got.saturated);
				return;
			end
			want = pending.pop_front();
			if (got.square_sum !== want.square_sum || got.distance !== want.distance ||
					got.saturated !== want.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch exp sum=%0d dist=%0d sat=%0b got sum=%0d dist=%0d sat=%0b",
						$time, want.square_sum, want.distance, want.saturated,
						got.square_sum, got.distance, got.saturated);
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	distance_scoreboard sb;

	// Sender pacing: bursts of random length separated by random gaps.
	bit paced = 1'b1;
	int burst_left = 0;
	// Raised by the stimulus to ask the receiver for one long hold-off.
	bit hold_request = 1'b0;

	euclidean_distance_engine uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Check every result transaction at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
	end

	// Offer one pair, hold it until accepted, then optionally idle before the next one.
	// Called at a falling edge and returns at a falling edge.
	task automatic push_pair(input logic [VALUE_W-1:0] a, input logic [VALUE_W-1:0] b,
			input bit last);
		item_t it;
		int    gap;
		it.a_value = a;
		it.b_value = b;
		it.last_element = last;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		sb.note_pair(it);
		@(negedge clk);
		if (paced) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				// Mostly short bursts, now and then a long stretch with no gaps at all.
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) :
					$urandom_range(0, 20);
				gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 7);
				if (gap > 0) begin
					item_valid <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
		end
	endtask

	// Bias samples toward the corners of the Q8.8 range and small magnitudes.
	function automatic logic [VALUE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			4, 5: return 16'($urandom_range(0, 600)) - 16'd300;
			default: return 16'($urandom);
		endcase
	endfunction

	// Receiver: stall on a pattern picked at random from four modes, each held for a random
	// stretch; on request hold off for a long stretch so the block backs up into its input.
	initial begin : result_sink
		sink_mode_t mode;
		int         left;
		int         tick;
		mode = SINK_OPEN;
		left = 0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end
			if (left == 0) begin
				mode = sink_mode_t'($urandom_range(0, 3));
				left = $urandom_range(16, 96);
			end
			left--;
			tick++;
			case (mode)
				SINK_OPEN:     result_ready <= 1'b1;
				SINK_MOSTLY:   result_ready <= ($urandom_range(0, 3) != 0);
				SINK_SPARSE:   result_ready <= ($urandom_range(0, 3) == 0);
				SINK_PERIODIC: result_ready <= (tick % 3 == 0);
				default:       result_ready <= 1'b1;
			endcase
		end
	end

	initial begin : stimulus
		int random_items;
		int next_squeeze;
		int len;
		sb = new();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: corners of the sample range, one-element and multi-element vectors.
		push_pair(16'h0000, 16'h0000, 1'b1);
		push_pair(16'h7FFF, 16'h8000, 1'b1);
		push_pair(16'h8000, 16'h7FFF, 1'b1);
		push_pair(16'h8000, 16'h8000, 1'b1);
		push_pair(16'h0100, 16'h0000, 1'b1);
		push_pair(16'h0001, 16'h0000, 1'b0);
		push_pair(16'h0000, 16'h0001, 1'b0);
		push_pair(16'hFFFF, 16'h0001, 1'b1);
		push_pair(16'h0300, 16'h0000, 1'b0);
		push_pair(16'h0000, 16'h0400, 1'b1);
		push_pair(16'h7FFF, 16'h7FFF, 1'b0);
		push_pair(16'hFFFF, 16'hFFFF, 1'b1);
		push_pair(16'h1234, 16'hEDCB, 1'b0);
		push_pair(16'h8000, 16'h0000, 1'b0);
		push_pair(16'h7FFF, 16'h0000, 1'b1);

		// Random vectors, mostly short; twice stall the receiver while a run of
		// one-element vectors keeps coming, so the block must drop item_ready.
		random_items = 0;
		next_squeeze = 500;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items >= next_squeeze) begin
				next_squeeze = next_squeeze + 700;
				paced = 1'b0;
				hold_request = 1'b1;
				repeat (16) push_pair(pick_sample(), pick_sample(), 1'b1);
				random_items = random_items + 16;
				paced = 1'b1;
			end else begin
				len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 4) :
					$urandom_range(5, 40);
				for (int k = 1; k <= len; k++)
					push_pair(pick_sample(), pick_sample(), k == len);
				random_items = random_items + len;
			end
		end
		item_valid <= 1'b0;

		// Drain: wait for every owed result, then give the block time to misbehave.
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: well above the slowest legal run.
	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
